/* rtl/core/pslt_pkg.sv */
// ----------------------------------------------------------------------------
// pslt_pkg
// shared types and constants of the per-source packet loss tracker
// ----------------------------------------------------------------------------
package pslt_pkg;

    localparam int ENTRIES    = 32;
    localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 104;
    localparam int SLOT_W     = 5;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    typedef enum logic [2:0] {
        ST_COUNTED   = 3'd0,
        ST_DUP       = 3'd1,
        ST_UNCOUNTED = 3'd2,
        ST_REJECT    = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CLUSTER = 3'd0,
        CFG_COMMAND = 3'd1,
        CFG_COUNTED = 3'd2,
        CFG_POSE    = 3'd3,
        CFG_GAP     = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_TAIL,
        S_READ,
        S_UPDATE,
        S_PUSH
    } t_state;

    typedef struct packed {
        logic [15:0] cluster;
        logic [7:0]  command;
        logic [7:0]  counted_size;
        logic [7:0]  pose_size;
        logic [15:0] gap_limit;
    } t_cfg;

    // request fields, highest bits first
    typedef struct packed {
        logic [31:0] now_ms;
        logic [15:0] source_addr;
        logic [15:0] seq_number;
        logic [7:0]  payload_size;
        logic [7:0]  command_id;
        logic [15:0] cluster_id;
    } t_frame;

    // result fields, highest bits first
    typedef struct packed {
        logic [31:0]       byte_total;
        logic [31:0]       drop_total;
        logic [31:0]       recv_total;
        logic [SLOT_W-1:0] slot;
        t_status           status;
    } t_result;

    typedef struct packed {
        logic [15:0] addr;
        logic [15:0] prev_seq;
        logic [31:0] recv;
        logic [31:0] drops;
        logic [31:0] bytes;
        logic [31:0] first_ms;
        logic [31:0] last_ms;
    } t_rec;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_idx;
        logic             wr_en;
        logic [IDX_W-1:0] wr_idx;
        t_rec             wr_rec;
    } t_tbl_req;

endpackage

/* rtl/core/per_source_packet_loss_tracker.sv */
// ----------------------------------------------------------------------------
// per_source_packet_loss_tracker
// counts received frames, bytes and sequence gaps for each sending source
// ----------------------------------------------------------------------------
// Each request on the slave stream carries one received frame; each request
// on the master stream carries exactly one result for it, in order.
// Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_wdata; the user
// must write it only while the block is idle, which the block does not
// enforce; indices above the last register are ignored. Rejected and
// accepted-uncounted frames go from acceptance straight to the push step; the
// next frame is taken only after their result is pushed. Counted frames scan
// all ENTRIES table entries through the single read port of the entry memory,
// one entry per cycle, then read and update the chosen entry and write it back
// unless the frame is a duplicate; with no matching or empty entry they get a
// full result. One frame is in flight at a time.
// Reset empties the table at once through per-entry valid bits and restores
// the configuration defaults; no clearing pass is needed.
// A finished result waits in the output register while the master stream
// stalls, and the next frame is taken and worked on meanwhile; it holds in
// its final step until the output register is free.
// ----------------------------------------------------------------------------
module per_source_packet_loss_tracker
    import pslt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // cluster_id, command_id, payload_size, seq_number, source_addr, now_ms
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // status, slot, recv_total, drop_total, byte_total
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cfg     w_cfg;
    t_tbl_req w_tbl;
    t_rec     w_rd_rec;
    t_frame   w_frame;
    t_result  w_res;

    assign w_frame        = t_frame'(i_s_axis_tdata);
    assign o_m_axis_tdata = OUT_DATA_W'(w_res);

    pslt_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    pslt_table u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_tbl),
        .o_rd_rec (w_rd_rec)
    );

    pslt_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_in_frame  (w_frame),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_res   (w_res),
        .o_tbl       (w_tbl),
        .i_rd_rec    (w_rd_rec)
    );

endmodule

/* rtl/core/pslt_cfg.sv */
// ----------------------------------------------------------------------------
// pslt_cfg
// configuration registers, written through a plain index/data port
// ----------------------------------------------------------------------------
module pslt_cfg
    import pslt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cluster      <= 16'hFC00;
            r_cfg.command      <= 8'h01;
            r_cfg.counted_size <= 8'd50;
            r_cfg.pose_size    <= 8'd15;
            r_cfg.gap_limit    <= 16'd1000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CLUSTER: r_cfg.cluster      <= i_cfg_wdata;
                CFG_COMMAND: r_cfg.command      <= i_cfg_wdata[7:0];
                CFG_COUNTED: r_cfg.counted_size <= i_cfg_wdata[7:0];
                CFG_POSE:    r_cfg.pose_size    <= i_cfg_wdata[7:0];
                CFG_GAP:     r_cfg.gap_limit    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/core/pslt_table.sv */
// ----------------------------------------------------------------------------
// pslt_table
// per-source entry memory with registered read and per-entry valid bits
// ----------------------------------------------------------------------------
module pslt_table
    import pslt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_tbl_req i_req,
    output t_rec     o_rd_rec
);

    t_rec               mem [ENTRIES];
    logic [ENTRIES-1:0] r_valid;
    t_rec               r_rd_data;
    logic               r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.wr_idx] <= i_req.wr_rec;
        end
        if (i_req.rd_en) begin
            r_rd_data <= mem[i_req.rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_valid[i_req.wr_idx] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_valid <= r_valid[i_req.rd_idx];
            end
        end
    end

    // never written entries read as empty
    assign o_rd_rec = r_rd_valid ? r_rd_data : '0;

endmodule

/* rtl/core/pslt_engine.sv */
// ----------------------------------------------------------------------------
// pslt_engine
// frame filter, linear entry search and read-modify-write of one entry
// ----------------------------------------------------------------------------
module pslt_engine
    import pslt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_frame   i_in_frame,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_result  o_out_res,
    output t_tbl_req o_tbl,
    input  t_rec     i_rd_rec
);

    t_state           r_state;
    t_state           n_state;
    t_frame           r_frame;
    t_result          r_res;
    t_result          r_out;
    logic             r_out_vld;
    logic [IDX_W-1:0] r_idx;
    logic             r_pend;
    logic [IDX_W-1:0] r_pend_idx;
    logic             r_hit;
    logic [IDX_W-1:0] r_hit_idx;
    logic             r_emp;
    logic [IDX_W-1:0] r_emp_idx;
    logic [IDX_W-1:0] r_sel_idx;
    logic             r_claim;

    logic             w_accept;
    logic             w_pass;
    logic             w_pose;
    logic             w_counted;
    logic             w_push;
    logic [IDX_W-1:0] w_choice;
    t_rec             w_base;
    t_rec             w_new;
    logic [15:0]      w_diff;
    logic             w_dup;
    logic             w_gap_add;
    logic [31:0]      w_sel32;
    t_result          w_upd_res;
    t_result          w_front_res;
    t_result          w_full_res;

    // frame filter
    assign w_accept  = i_in_valid && o_in_ready;
    assign w_pass    = (i_in_frame.cluster_id == i_cfg.cluster)
                    && (i_in_frame.command_id == i_cfg.command);
    assign w_pose    = i_in_frame.payload_size == i_cfg.pose_size;
    assign w_counted = w_pass && !w_pose
                    && (i_in_frame.payload_size == i_cfg.counted_size);
    assign w_push    = !r_out_vld || i_out_ready;
    assign w_choice  = r_hit ? r_hit_idx : r_emp_idx;

    // results without an entry
    always_comb begin
        w_front_res        = '0;
        w_front_res.status = (w_pass && w_pose) ? ST_UNCOUNTED : ST_REJECT;
        w_full_res         = '0;
        w_full_res.status  = ST_FULL;
    end

    // entry update
    always_comb begin
        w_base    = r_claim ? '0 : i_rd_rec;
        w_diff    = r_frame.seq_number - w_base.prev_seq;
        w_dup     = !r_claim && (w_diff == 16'd0);
        w_gap_add = !r_claim && (w_diff > 16'd1) && (w_diff < i_cfg.gap_limit);
        w_new          = w_base;
        w_new.addr     = r_frame.source_addr;
        w_new.prev_seq = r_frame.seq_number;
        w_new.recv     = w_base.recv + 32'd1;
        w_new.drops    = w_base.drops + (w_gap_add ? 32'(w_diff - 16'd1) : 32'd0);
        w_new.bytes    = w_base.bytes + 32'(r_frame.payload_size);
        w_new.first_ms = (w_new.recv == 32'd1) ? r_frame.now_ms : w_base.first_ms;
        w_new.last_ms  = r_frame.now_ms;
        w_sel32        = 32'(r_sel_idx);
        w_upd_res.slot = w_sel32[SLOT_W-1:0];
        if (w_dup) begin
            w_upd_res.status     = ST_DUP;
            w_upd_res.recv_total = w_base.recv;
            w_upd_res.drop_total = w_base.drops;
            w_upd_res.byte_total = w_base.bytes;
        end else begin
            w_upd_res.status     = ST_COUNTED;
            w_upd_res.recv_total = w_new.recv;
            w_upd_res.drop_total = w_new.drops;
            w_upd_res.byte_total = w_new.bytes;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = w_counted ? S_SCAN : S_PUSH;
                end
            end
            S_SCAN: begin
                if (r_idx == LAST_IDX) begin
                    n_state = S_TAIL;
                end
            end
            S_TAIL:   n_state = S_READ;
            S_READ:   n_state = (r_hit || r_emp) ? S_UPDATE : S_PUSH;
            S_UPDATE: n_state = S_PUSH;
            S_PUSH: begin
                if (w_push) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready    = 1'b0;
        o_tbl.rd_en   = 1'b0;
        o_tbl.rd_idx  = r_idx;
        o_tbl.wr_en   = 1'b0;
        o_tbl.wr_idx  = r_sel_idx;
        o_tbl.wr_rec  = w_new;
        unique case (r_state)
            S_IDLE:   o_in_ready = 1'b1;
            S_SCAN:   o_tbl.rd_en = 1'b1;
            S_READ: begin
                o_tbl.rd_en  = 1'b1;
                o_tbl.rd_idx = w_choice;
            end
            S_UPDATE: o_tbl.wr_en = !w_dup;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
            r_pend    <= 1'b0;
            r_hit     <= 1'b0;
            r_emp     <= 1'b0;
            r_idx     <= '0;
        end else begin
            r_state <= n_state;
            r_pend  <= r_state == S_SCAN;

            // search compare on returned entries, lowest index wins
            if (r_pend) begin
                if (!r_hit && (i_rd_rec.addr == r_frame.source_addr)) begin
                    r_hit     <= 1'b1;
                    r_hit_idx <= r_pend_idx;
                end
                if (!r_emp && (i_rd_rec.addr == 16'd0)) begin
                    r_emp     <= 1'b1;
                    r_emp_idx <= r_pend_idx;
                end
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_frame <= i_in_frame;
                        r_hit   <= 1'b0;
                        r_emp   <= 1'b0;
                        r_idx   <= '0;
                        r_res   <= w_front_res;
                    end
                end
                S_SCAN: begin
                    r_pend_idx <= r_idx;
                    if (r_idx != LAST_IDX) begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_READ: begin
                    r_sel_idx <= w_choice;
                    r_claim   <= !r_hit;
                    r_res     <= w_full_res;
                end
                S_UPDATE: r_res <= w_upd_res;
                default: ;
            endcase

            if (r_state == S_PUSH && w_push) begin
                r_out_vld <= 1'b1;
                r_out     <= r_res;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_res   = r_out;

endmodule

/* rtl/core/pslt_checker.sv */
// ----------------------------------------------------------------------------
// pslt_checker
// port-level checks of the packet loss tracker, bound to the top level
// ----------------------------------------------------------------------------
module pslt_checker
    import pslt_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_axis_tvalid,
    input logic                  o_s_axis_tready,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    logic w_no_entry;

    assign w_no_entry = (o_m_axis_tdata[2:0] == ST_REJECT)
                     || (o_m_axis_tdata[2:0] == ST_UNCOUNTED)
                     || (o_m_axis_tdata[2:0] == ST_FULL);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    // one frame in flight
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("frame taken while another is in work");

    // results without an entry carry no totals
    a_no_entry_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && w_no_entry |-> o_m_axis_tdata[OUT_DATA_W-1:3] == '0)
        else $error("entry fields set on a result without an entry");

    // reset leaves no result pending
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result pending after reset");

endmodule

bind per_source_packet_loss_tracker pslt_checker u_pslt_checker (.*);

/* tb/per_source_packet_loss_tracker_tb.sv */
// ----------------------------------------------------------------------------
// per_source_packet_loss_tracker_tb
// checks the per-source loss tracker against a cycle-free behavioural copy
// of its table: directed frames for the corner cases, then phases of random
// traffic under several register settings, with random stalls on both
// streams, a long output hold-off and a run that fills the source table
// ----------------------------------------------------------------------------
module per_source_packet_loss_tracker_tb;
    import pslt_pkg::*;

    localparam logic [15:0] DEF_CLUSTER = 16'hFC00;
    localparam logic [7:0]  DEF_COMMAND = 8'h01;
    localparam logic [7:0]  DEF_COUNTED = 8'd50;
    localparam logic [7:0]  DEF_POSE    = 8'd15;
    localparam logic [15:0] DEF_GAP     = 16'd1000;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam int HOLD_OFF_CYCLES = 400;
    localparam int END_WAIT        = 100;
    localparam int MAX_REPORTS     = 10;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    // cluster_id, command_id, payload_size, seq_number, source_addr, now_ms
    logic [IN_DATA_W-1:0]  i_s_axis_tdata;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    // status, slot, recv_total, drop_total, byte_total
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    per_source_packet_loss_tracker dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // register copies
    logic [15:0] cfg_cluster;
    logic [7:0]  cfg_command;
    logic [7:0]  cfg_counted;
    logic [7:0]  cfg_pose;
    logic [15:0] cfg_gap;

    // source table copy
    logic [15:0] src_key      [ENTRIES];
    bit          src_fresh    [ENTRIES];
    logic [15:0] src_prev_seq [ENTRIES];
    logic [31:0] src_recv     [ENTRIES];
    logic [31:0] src_drops    [ENTRIES];
    logic [31:0] src_bytes    [ENTRIES];

    t_result     loss_reports_due[$];
    logic [15:0] source_pool[$];
    int          mismatch_count = 0;
    bit          quiet_mode     = 1'b0;
    bit          hold_off_req   = 1'b0;

    function automatic int slot_of(logic [15:0] addr);
        for (int i = 0; i < ENTRIES; i++) begin
            if (src_key[i] == addr) return i;
        end
        return -1;
    endfunction

    function automatic t_result track_frame(t_frame f);
        t_result     res;
        int          e;
        logic [15:0] diff;
        res = '0;
        res.status = ST_REJECT;
        if (f.cluster_id != cfg_cluster || f.command_id != cfg_command) return res;
        if (f.payload_size == cfg_pose) begin
            res.status = ST_UNCOUNTED;
            return res;
        end
        if (f.payload_size != cfg_counted) return res;
        // address zero finds the lowest empty slot as if it were its own
        e = slot_of(f.source_addr);
        if (e < 0) begin
            e = slot_of(16'h0000);
            if (e < 0) begin
                res.status = ST_FULL;
                return res;
            end
            src_key[e]      = f.source_addr;
            src_fresh[e]    = 1'b1;
            src_prev_seq[e] = '0;
            src_recv[e]     = '0;
            src_drops[e]    = '0;
            src_bytes[e]    = '0;
        end
        res.status = ST_COUNTED;
        if (!src_fresh[e]) begin
            diff = f.seq_number - src_prev_seq[e];
            if (diff == 16'd0) begin
                res.status = ST_DUP;
            end else if (diff > 16'd1 && diff < cfg_gap) begin
                src_drops[e] = src_drops[e] + 32'(diff) - 32'd1;
            end
        end else begin
            src_fresh[e] = 1'b0;
        end
        if (res.status == ST_COUNTED) begin
            src_prev_seq[e] = f.seq_number;
            src_recv[e]     = src_recv[e] + 32'd1;
            src_bytes[e]    = src_bytes[e] + 32'(f.payload_size);
        end
        res.slot       = SLOT_W'(e);
        res.recv_total = src_recv[e];
        res.drop_total = src_drops[e];
        res.byte_total = src_bytes[e];
        return res;
    endfunction

    function automatic t_frame make_frame(logic [15:0] cluster, logic [7:0] command,
                                          logic [7:0] size, logic [15:0] seq,
                                          logic [15:0] src, logic [31:0] now);
        t_frame f;
        f.cluster_id   = cluster;
        f.command_id   = command;
        f.payload_size = size;
        f.seq_number   = seq;
        f.source_addr  = src;
        f.now_ms       = now;
        return f;
    endfunction

    // mostly the next sequence, with duplicates, short gaps and gaps near the limit
    function automatic logic [15:0] seq_after(logic [15:0] src);
        int          e;
        int          r;
        logic [15:0] base;
        e = slot_of(src);
        base = (e < 0) ? 16'($urandom) : src_prev_seq[e];
        r = $urandom_range(0, 99);
        if (r < 50) return base + 16'd1;
        if (r < 60) return base;
        if (r < 85) return base + 16'($urandom_range(2, 20));
        if (r < 92) return base + cfg_gap + 16'($urandom_range(0, 2)) - 16'd1;
        return 16'($urandom);
    endfunction

    function automatic int idle_gap();
        int r;
        if (quiet_mode) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_frame(input t_frame f);
        int gap;
        gap = idle_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= f;
        do @(posedge i_clk); while (!o_s_axis_tready);
        loss_reports_due.push_back(track_frame(f));
    endtask

    task automatic drain_results;
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (loss_reports_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_CLUSTER: cfg_cluster = value;
            CFG_COMMAND: cfg_command = value[7:0];
            CFG_COUNTED: cfg_counted = value[7:0];
            CFG_POSE:    cfg_pose    = value[7:0];
            CFG_GAP:     cfg_gap     = value;
            default: ;
        endcase
    endtask

    task automatic test_reset_defaults;
        // field extremes, rejects and an uncounted frame
        send_frame(make_frame(16'h0000, cfg_command, cfg_counted, 16'h0000, 16'h0001, 32'h0));
        send_frame(make_frame(16'hFFFF, cfg_command, cfg_counted, 16'hFFFF, 16'h0001, 32'h0));
        send_frame(make_frame(cfg_cluster, 8'h00, cfg_counted, 16'h0000, 16'h0001, 32'h0));
        send_frame(make_frame(cfg_cluster, 8'hFF, cfg_counted, 16'h0000, 16'h0001, 32'h0));
        send_frame(make_frame(cfg_cluster, cfg_command, 8'h00, 16'h0000, 16'h0001, 32'h0));
        send_frame(make_frame(cfg_cluster, cfg_command, 8'hFF, 16'h0000, 16'h0001, 32'h0));
        send_frame(make_frame(cfg_cluster, cfg_command, cfg_pose, 16'hFFFF, 16'h0000,
                              32'hFFFF_FFFF));
        // fresh claim, duplicate, wrap, gaps below and at the limit
        send_frame(make_frame(cfg_cluster, cfg_command, cfg_counted, 16'hFFFF, 16'hFFFF,
                              32'hFFFF_FFFF));
        send_frame(make_frame(cfg_cluster, cfg_command, cfg_counted, 16'hFFFF, 16'hFFFF, 32'h1));
        send_frame(make_frame(cfg_cluster, cfg_command, cfg_counted, 16'h0000, 16'hFFFF, 32'h2));
        send_frame(make_frame(cfg_cluster, cfg_command, cfg_counted, 16'h0002, 16'hFFFF, 32'h3));
        send_frame(make_frame(cfg_cluster, cfg_command, cfg_counted, 16'h03E9, 16'hFFFF, 32'h4));
        send_frame(make_frame(cfg_cluster, cfg_command, cfg_counted, 16'h07D1, 16'hFFFF, 32'h5));
        send_frame(make_frame(cfg_cluster, cfg_command, cfg_counted, 16'h87D1, 16'hFFFF, 32'h6));
        // address zero rides on the lowest empty slot, a later claim clears it
        send_frame(make_frame(cfg_cluster, cfg_command, cfg_counted, 16'h0005, 16'h0000, 32'h7));
        send_frame(make_frame(cfg_cluster, cfg_command, cfg_counted, 16'h0006, 16'h0000, 32'h8));
        send_frame(make_frame(cfg_cluster, cfg_command, cfg_counted, 16'h0100, 16'h1234, 32'h9));
        send_frame(make_frame(cfg_cluster, cfg_command, cfg_counted, 16'h0000, 16'h0000, 32'hA));
        send_frame(make_frame(cfg_cluster, cfg_command, cfg_counted, 16'h0000, 16'h8001, 32'hB));
        drain_results();
    endtask

    task automatic test_register_settings;
        logic [15:0] seq;
        write_reg(CFG_CLUSTER, 16'h0000);
        write_reg(CFG_COMMAND, 16'hA5FF);
        write_reg(CFG_COUNTED, 16'h5AFF);
        write_reg(CFG_POSE, 16'hFF00);
        write_reg(CFG_GAP, 16'd2);
        seq = src_prev_seq[slot_of(16'hFFFF)];
        send_frame(make_frame(cfg_cluster, cfg_command, cfg_counted, seq + 16'd2, 16'hFFFF,
                              32'h0));
        send_frame(make_frame(cfg_cluster, cfg_command, 8'h00, 16'h0000, 16'hFFFF, 32'h0));
        drain_results();
        // equal sizes: uncounted wins
        write_reg(CFG_COUNTED, 16'h003C);
        write_reg(CFG_POSE, 16'h003C);
        write_reg(CFG_GAP, 16'd1);
        send_frame(make_frame(cfg_cluster, cfg_command, 8'h3C, 16'h0000, 16'hFFFF, 32'h0));
        drain_results();
        write_reg(CFG_POSE, 16'h0010);
        seq = src_prev_seq[slot_of(16'hFFFF)];
        send_frame(make_frame(cfg_cluster, cfg_command, cfg_counted, seq + 16'd5, 16'hFFFF,
                              32'h0));
        drain_results();
        // writes past the last register leave every setting alone
        for (int i = CFG_SPARE_LO; i <= CFG_SPARE_HI; i++) begin
            write_reg(CFG_IDX_W'(i), 16'($urandom));
        end
        seq = src_prev_seq[slot_of(16'hFFFF)];
        send_frame(make_frame(cfg_cluster, cfg_command, cfg_counted, seq + 16'd3, 16'hFFFF,
                              32'h0));
        send_frame(make_frame(16'hFFFF, cfg_command, cfg_counted, seq, 16'hFFFF, 32'h0));
        drain_results();
        write_reg(CFG_GAP, 16'hFFFF);
        seq = src_prev_seq[slot_of(16'hFFFF)];
        send_frame(make_frame(cfg_cluster, cfg_command, cfg_counted, seq + 16'hFFFF, 16'hFFFF,
                              32'h0));
        seq = src_prev_seq[slot_of(16'hFFFF)];
        send_frame(make_frame(cfg_cluster, cfg_command, cfg_counted, seq + 16'hFFFE, 16'hFFFF,
                              32'h0));
        drain_results();
    endtask

    task automatic run_random_phase(input int n_items, input logic [15:0] gap_limit,
                                    input bit quiet, input bit hold_off);
        t_frame      f;
        logic [15:0] src;
        logic [7:0]  pose;
        int          r;
        drain_results();
        write_reg(CFG_CLUSTER, 16'($urandom));
        write_reg(CFG_COMMAND, 16'($urandom));
        write_reg(CFG_COUNTED, 16'($urandom));
        pose = 8'($urandom);
        if (pose == cfg_counted) pose = pose + 8'd1;
        write_reg(CFG_POSE, {8'($urandom), pose});
        write_reg(CFG_GAP, gap_limit);
        quiet_mode   = quiet;
        hold_off_req = hold_off;
        repeat (n_items) begin
            r   = $urandom_range(0, 99);
            src = 16'($urandom);
            if (r < 70) begin
                src = source_pool[$urandom_range(0, source_pool.size() - 1)];
                f = make_frame(cfg_cluster, cfg_command, cfg_counted, seq_after(src), src,
                               $urandom);
            end else if (r < 76) begin
                f = make_frame(cfg_cluster, cfg_command, cfg_counted, 16'($urandom), src,
                               $urandom);
            end else if (r < 78) begin
                f = make_frame(cfg_cluster, cfg_command, cfg_counted, seq_after(16'h0000),
                               16'h0000, $urandom);
            end else if (r < 86) begin
                f = make_frame(cfg_cluster, cfg_command, cfg_pose, 16'($urandom), src,
                               $urandom);
            end else if (r < 93) begin
                if ($urandom_range(0, 1) == 0) begin
                    f = make_frame(cfg_cluster ^ 16'($urandom_range(1, 65535)), cfg_command,
                                   cfg_counted, 16'($urandom), src, $urandom);
                end else begin
                    f = make_frame(cfg_cluster, cfg_command ^ 8'($urandom_range(1, 255)),
                                   cfg_counted, 16'($urandom), src, $urandom);
                end
            end else begin
                f = make_frame(cfg_cluster, cfg_command, 8'($urandom), 16'($urandom), src,
                               $urandom);
            end
            send_frame(f);
            if (r >= 70 && r < 76 && src != 16'h0000 && slot_of(src) >= 0) begin
                source_pool.push_back(src);
            end
        end
        quiet_mode = 1'b0;
    endtask

    task automatic test_table_full;
        logic [15:0] src;
        drain_results();
        write_reg(CFG_CLUSTER, DEF_CLUSTER);
        write_reg(CFG_COMMAND, 16'(DEF_COMMAND));
        write_reg(CFG_COUNTED, 16'(DEF_COUNTED));
        write_reg(CFG_POSE, 16'(DEF_POSE));
        write_reg(CFG_GAP, DEF_GAP);
        while (slot_of(16'h0000) >= 0) begin
            src = 16'($urandom_range(1, 65535));
            if (slot_of(src) < 0) begin
                send_frame(make_frame(cfg_cluster, cfg_command, cfg_counted, 16'($urandom),
                                      src, $urandom));
                source_pool.push_back(src);
            end
        end
        do src = 16'($urandom_range(1, 65535)); while (slot_of(src) >= 0);
        send_frame(make_frame(cfg_cluster, cfg_command, cfg_counted, 16'h0000, src, $urandom));
        send_frame(make_frame(cfg_cluster, cfg_command, cfg_counted, 16'h0000, 16'h0000,
                              $urandom));
        src = source_pool[0];
        send_frame(make_frame(cfg_cluster, cfg_command, cfg_counted, seq_after(src), src,
                              $urandom));
        drain_results();
    endtask

    // result side: random stalls, and the long hold-off when asked
    initial begin
        int stall;
        forever begin
            @(negedge i_clk);
            stall = hold_off_req ? HOLD_OFF_CYCLES : idle_gap();
            hold_off_req = 1'b0;
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = t_result'(o_m_axis_tdata);
            if (loss_reports_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("unexpected result: status %0d slot %0d recv %0d drops %0d bytes %0d",
                             got.status, got.slot, got.recv_total, got.drop_total,
                             got.byte_total);
                end
            end else begin
                want = loss_reports_due.pop_front();
                if (got.status !== want.status || got.slot !== want.slot ||
                    got.recv_total !== want.recv_total || got.drop_total !== want.drop_total ||
                    got.byte_total !== want.byte_total) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("mismatch: expected status %0d slot %0d recv %0d drops %0d bytes %0d",
                                 want.status, want.slot, want.recv_total, want.drop_total,
                                 want.byte_total);
                        $display("          actual   status %0d slot %0d recv %0d drops %0d bytes %0d",
                                 got.status, got.slot, got.recv_total, got.drop_total,
                                 got.byte_total);
                    end
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_m_axis_tready = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = '0;
        i_cfg_wdata     = '0;
        cfg_cluster     = DEF_CLUSTER;
        cfg_command     = DEF_COMMAND;
        cfg_counted     = DEF_COUNTED;
        cfg_pose        = DEF_POSE;
        cfg_gap         = DEF_GAP;
        for (int i = 0; i < ENTRIES; i++) begin
            src_key[i]      = '0;
            src_fresh[i]    = 1'b0;
            src_prev_seq[i] = '0;
            src_recv[i]     = '0;
            src_drops[i]    = '0;
            src_bytes[i]    = '0;
        end
        source_pool = '{16'hFFFF, 16'h1234, 16'h8001};
        repeat (10) source_pool.push_back(16'($urandom_range(1, 65535)));
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_register_settings();
        run_random_phase(90, 16'($urandom_range(2, 64)), 1'b0, 1'b0);
        run_random_phase(90, 16'd0, 1'b0, 1'b1);
        run_random_phase(80, 16'hFFFF, 1'b1, 1'b0);
        test_table_full();
        run_random_phase(90, 16'($urandom_range(2, 300)), 1'b0, 1'b0);
        drain_results();
        repeat (END_WAIT) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
